### hw/rtl/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg: shared types and constants for the status packet deframer
// Holds the framing constants and the command and status structs that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package spd_pkg;

   localparam logic [7:0] SYNC_A          = 8'd205;
   localparam logic [7:0] SYNC_B          = 8'd235;
   localparam logic [7:0] SYNC_C          = 8'd215;
   localparam logic [7:0] SEPARATOR_VALUE = 8'd32;
   localparam int         SEPARATOR_CHECKS = 7;
   localparam int         BYTES_PER_WORD = 5;

   // Word position within a payload: at most 255 / 5 = 51.
   localparam int         WPOS_W = 6;
   // Byte position within a five-byte group.
   localparam int         KPOS_W = 3;

   localparam logic [KPOS_W-1:0] KPOS_SEP  = 3'd4;
   localparam logic [KPOS_W-1:0] KPOS_TOP  = 3'd3;

   typedef struct packed {
      logic take;   // an input item is accepted this cycle
      logic read;   // read the word store at the emit index
      logic next;   // the current result item has been taken
   } spd_cmd_type;

   typedef struct packed {
      logic pkt_done;  // the offered byte completes a full-length payload
      logic idx_last;  // the emit index points at the final word
   } spd_status_type;

endpackage

### hw/rtl/status_packet_deframer.sv
// ----------------------------------------------------------------------------
// status_packet_deframer: sync and length framed status packet receiver
// Received bytes enter on the req_ channel, one item per byte. The sequence
// 205,235,215 starts a packet wherever it appears; the next byte is the
// payload length. When a payload of five bytes per word for WORD_COUNT words
// completes, the rsp_ channel delivers WORD_COUNT items: the index, the
// little-endian 32-bit word, the separator check and a last marker.
// Bytes are taken one per cycle while no packet is being emitted. The byte
// that completes a full packet stops intake; the first word, and each further
// word once the previous one is taken, passes through the READ state and then
// appears in the SHOW state, since every word goes through one registered read
// of the word store. Intake resumes in the cycle after the last word is taken.
// A stalled receiver simply holds the current word on the rsp_ ports, and
// intake waits with it.
// Synchronous reset returns to byte intake with no packet in progress; the
// word store is not cleared, as every word is written before it is read.
// ----------------------------------------------------------------------------
module status_packet_deframer #(
   parameter int WORD_COUNT = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_word_index,
   output logic [31:0] rsp_word_value,
   output logic        rsp_separators_ok,
   output logic        rsp_last
);
   import spd_pkg::*;

   spd_cmd_type    cmd;
   spd_status_type status;

   spd_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   spd_datapath #(
      .WORD_COUNT (WORD_COUNT)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .rx_byte       (req_rx_byte),
      .word_index    (rsp_word_index),
      .word_value    (rsp_word_value),
      .separators_ok (rsp_separators_ok),
      .last          (rsp_last)
   );

endmodule

### hw/rtl/spd_datapath.sv
// ----------------------------------------------------------------------------
// spd_datapath: byte framing, word assembly and word store
// Tracks the sync sequence, length and payload position, assembles words
// into a store, and reads them back one at a time for emission.
// ----------------------------------------------------------------------------
module spd_datapath #(
   parameter int WORD_COUNT = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   input  spd_pkg::spd_cmd_type    cmd,
   output spd_pkg::spd_status_type status,
   input  logic [7:0]             rx_byte,
   output logic [4:0]             word_index,
   output logic [31:0]            word_value,
   output logic                   separators_ok,
   output logic                   last
);
   import spd_pkg::*;

   localparam int IDX_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam logic [7:0] FULL_LEN = 8'(BYTES_PER_WORD * WORD_COUNT);
   localparam logic [WPOS_W-1:0] WORD_LIMIT = WPOS_W'(WORD_COUNT);
   localparam logic [WPOS_W-1:0] SEP_LIMIT  = WPOS_W'(SEPARATOR_CHECKS);
   localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(WORD_COUNT - 1);

   logic [15:0]       prior_ff, prior_in;
   logic              await_ff, await_in;
   logic [7:0]        tgt_ff, tgt_in;
   logic [7:0]        rcv_ff, rcv_in;
   logic [WPOS_W-1:0] wpos_ff, wpos_in;
   logic [KPOS_W-1:0] kpos_ff, kpos_in;
   logic              sep_ff, sep_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [23:0]       asm_ff;
   logic [31:0]       rd_data_ff;
   logic [31:0]       mem [WORD_COUNT];

   logic              is_sync;
   logic              payload;
   logic              complete;
   logic [7:0]        rcv_next;
   logic              store_word;

   assign is_sync  = (prior_ff[15:8] == SYNC_A) && (prior_ff[7:0] == SYNC_B)
                     && (rx_byte == SYNC_C);
   assign payload  = !is_sync && !await_ff && (rcv_ff < tgt_ff);
   assign rcv_next = rcv_ff + 8'd1;
   assign complete = payload && (rcv_next == tgt_ff);
   assign store_word = cmd.take && payload && (kpos_ff == KPOS_TOP)
                       && (wpos_ff < WORD_LIMIT);

   assign status.pkt_done = complete && (tgt_ff == FULL_LEN);
   assign status.idx_last = (idx_ff == IDX_LAST);

   always_comb begin
      prior_in = prior_ff;
      await_in = await_ff;
      tgt_in   = tgt_ff;
      rcv_in   = rcv_ff;
      wpos_in  = wpos_ff;
      kpos_in  = kpos_ff;
      sep_in   = sep_ff;
      if (cmd.take) begin
         prior_in = {prior_ff[7:0], rx_byte};
         if (is_sync) begin
            await_in = 1'b1;
            tgt_in   = '0;
            rcv_in   = '0;
            wpos_in  = '0;
            kpos_in  = '0;
            sep_in   = 1'b1;
         end else if (await_ff) begin
            tgt_in   = rx_byte;
            await_in = 1'b0;
         end else if (payload) begin
            if ((kpos_ff == KPOS_SEP) && (wpos_ff < SEP_LIMIT)
                && (wpos_ff < WORD_LIMIT) && (rx_byte != SEPARATOR_VALUE)) begin
               sep_in = 1'b0;
            end
            if (complete) begin
               // Any finished packet drops back to ignoring bytes until a sync.
               tgt_in  = '0;
               rcv_in  = '0;
               wpos_in = '0;
               kpos_in = '0;
            end else begin
               rcv_in = rcv_next;
               if (kpos_ff == KPOS_SEP) begin
                  kpos_in = '0;
                  wpos_in = wpos_ff + WPOS_W'(1);
               end else begin
                  kpos_in = kpos_ff + KPOS_W'(1);
               end
            end
         end
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.next) begin
         idx_in = status.idx_last ? '0 : idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_ff <= '0;
         await_ff <= 1'b0;
         tgt_ff   <= '0;
         rcv_ff   <= '0;
         wpos_ff  <= '0;
         kpos_ff  <= '0;
         sep_ff   <= 1'b1;
         idx_ff   <= '0;
      end else begin
         prior_ff <= prior_in;
         await_ff <= await_in;
         tgt_ff   <= tgt_in;
         rcv_ff   <= rcv_in;
         wpos_ff  <= wpos_in;
         kpos_ff  <= kpos_in;
         sep_ff   <= sep_in;
         idx_ff   <= idx_in;
      end
   end

   // The low three bytes of a word are held here until its top byte arrives.
   always_ff @(posedge clock) begin
      if (cmd.take && payload) begin
         case (kpos_ff)
            3'd0:    asm_ff[7:0]   <= rx_byte;
            3'd1:    asm_ff[15:8]  <= rx_byte;
            3'd2:    asm_ff[23:16] <= rx_byte;
            default: asm_ff        <= asm_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (store_word) begin
         mem[wpos_ff[IDX_W-1:0]] <= {rx_byte, asm_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   assign word_index    = 5'(idx_ff);
   assign word_value    = rd_data_ff;
   assign separators_ok = sep_ff;
   assign last          = status.idx_last;

endmodule

### hw/rtl/spd_controller.sv
// ----------------------------------------------------------------------------
// spd_controller: sequencing of byte intake and word emission
// Takes bytes while idle and, after a full-length packet, walks the word
// store through a read and a present step for each word.
// ----------------------------------------------------------------------------
module spd_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output spd_pkg::spd_cmd_type    cmd,
   input  spd_pkg::spd_status_type status
);
   import spd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_SHOW = 2'd2;

   logic [1:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_SHOW);

   always_comb begin
      state_in = state_ff;
      cmd.take = 1'b0;
      cmd.read = 1'b0;
      cmd.next = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.take = req_valid;
            if (req_valid && status.pkt_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_ready) begin
               cmd.next = 1'b1;
               state_in = status.idx_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### test/status_packet_deframer_test.sv
// ----------------------------------------------------------------------------
// status_packet_deframer_test: self-checking bench for the status deframer
// Sends a byte stream of sync-framed packets through the req_ channel and
// predicts, byte by byte, the status words that each full-length packet
// releases. Every word taken on the rsp_ channel is compared field by field
// with the oldest prediction. Both sides insert random gaps, and the receiver
// holds off once for a long stretch so that the block stalls its intake.
// ----------------------------------------------------------------------------
module status_packet_deframer_test;
   import spd_pkg::*;

   localparam int         WORDS       = 25;
   localparam logic [7:0] FULL_LENGTH = 8'(BYTES_PER_WORD * WORDS);
   localparam int         HOLD_CYCLES = 300;
   localparam int         SETTLE      = 2 * WORDS + 20;

   typedef struct {
      logic [4:0]  index;
      logic [31:0] value;
      logic        seps_ok;
      logic        is_last;
   } status_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [4:0]  rsp_word_index;
   logic [31:0] rsp_word_value;
   logic        rsp_separators_ok;
   logic        rsp_last;

   // Stimulus and expectations.
   logic [7:0]      pending_bytes[$];
   status_word_type expected_words[$];
   int              words_predicted = 0;
   int              error_count = 0;

   // Handshake flags; the fire and hold-off flags are written at the rising edge and read at the falling one.
   bit req_fire = 1'b0;
   bit rsp_fire = 1'b0;
   bit hold_off = 1'b0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   int req_wait = 0;
   int rsp_wait = 0;

   // Deframer state as the bench sees it.
   logic [15:0] recent_bytes = 16'd0;
   logic        want_length = 1'b0;
   logic [7:0]  pkt_length = 8'd0;
   logic [7:0]  pkt_count = 8'd0;
   logic [31:0] assembly[WORDS];
   logic        seps_clean = 1'b1;

   status_word_type want;

   status_packet_deframer #(
      .WORD_COUNT(WORDS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_word_index    (rsp_word_index),
      .rsp_word_value    (rsp_word_value),
      .rsp_separators_ok (rsp_separators_ok),
      .rsp_last          (rsp_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Advances the predicted deframer by one received byte and queues the
   // status words that a completed full-length packet releases.
   function automatic void deframe_byte(input logic [7:0] b);
      logic [7:0]      older;
      logic [7:0]      newer;
      int              w;
      int              k;
      status_word_type sw;
      older = recent_bytes[15:8];
      newer = recent_bytes[7:0];
      recent_bytes = {newer, b};
      if (older == SYNC_A && newer == SYNC_B && b == SYNC_C) begin
         want_length = 1'b1;
         pkt_length = 8'd0;
         pkt_count = 8'd0;
         seps_clean = 1'b1;
      end else if (want_length) begin
         pkt_length = b;
         want_length = 1'b0;
      end else if (pkt_count < pkt_length) begin
         w = pkt_count / BYTES_PER_WORD;
         k = pkt_count % BYTES_PER_WORD;
         if (k == KPOS_SEP) begin
            if (w < SEPARATOR_CHECKS && w < WORDS && b != SEPARATOR_VALUE)
               seps_clean = 1'b0;
         end else if (w < WORDS) begin
            assembly[w][8*k +: 8] = b;
         end
         pkt_count = pkt_count + 8'd1;
         if (pkt_count == pkt_length) begin
            if (pkt_length == FULL_LENGTH) begin
               for (int j = 0; j < WORDS; j++) begin
                  sw.index = j[4:0];
                  sw.value = assembly[j];
                  sw.seps_ok = seps_clean;
                  sw.is_last = (j == WORDS - 1);
                  expected_words.push_back(sw);
               end
               words_predicted += WORDS;
            end
            pkt_length = 8'd0;
            pkt_count = 8'd0;
         end
      end
   endfunction

   function automatic void queue_sync();
      pending_bytes.push_back(SYNC_A);
      pending_bytes.push_back(SYNC_B);
      pending_bytes.push_back(SYNC_C);
   endfunction

   // A full-length packet header followed by the first count payload bytes.
   // Each word is random, all zeros or all ones; one checked separator is
   // spoilt when clean is low.
   function automatic void queue_status_packet(input bit clean, input int count);
      logic [7:0] b;
      int         bad;
      int         fill;
      bad = clean ? -1 : $urandom_range(0, SEPARATOR_CHECKS - 1);
      fill = 0;
      queue_sync();
      pending_bytes.push_back(FULL_LENGTH);
      for (int i = 0; i < count; i++) begin
         if (i % BYTES_PER_WORD == 0)
            fill = $urandom_range(0, 7);
         b = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom_range(0, 255));
         if (i % BYTES_PER_WORD == KPOS_SEP) begin
            b = 8'($urandom_range(0, 255));
            if (i / BYTES_PER_WORD == bad)
               b = (b == SEPARATOR_VALUE) ? SEPARATOR_VALUE + 8'd1 : b;
            else if (i / BYTES_PER_WORD < SEPARATOR_CHECKS || $urandom_range(0, 1) == 0)
               b = SEPARATOR_VALUE;
         end
         pending_bytes.push_back(b);
      end
   endfunction

   // A short packet of some length other than the full one; it releases
   // nothing.
   function automatic void queue_other_packet();
      int len;
      case ($urandom_range(0, 2))
         0: len = 0;
         1: len = 1;
         default: len = $urandom_range(2, 6);
      endcase
      queue_sync();
      pending_bytes.push_back(8'(len));
      for (int i = 0; i < len; i++)
         pending_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   // Loose bytes, often fragments of a sync sequence.
   function automatic void queue_noise();
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: pending_bytes.push_back(SYNC_A);
            1: pending_bytes.push_back(SYNC_B);
            default: pending_bytes.push_back(8'($urandom_range(0, 255)));
         endcase
      end
   endfunction

   // Sender: presents the next pending byte after its drawn gap.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_wait > 0) begin
            req_valid <= 1'b0;
            req_wait--;
         end else if (pending_bytes.size() > 0) begin
            req_valid <= 1'b1;
            req_rx_byte <= pending_bytes.pop_front();
            if ($urandom_range(0, 19) == 0)
               req_calm = !req_calm;
            req_wait = req_calm ? 0 : $urandom_range(0, 9);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: after each word it takes, it stalls for a drawn number of
   // cycles, and it refuses everything during the long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_fire) begin
            if ($urandom_range(0, 19) == 0)
               rsp_calm = !rsp_calm;
            rsp_wait = rsp_calm ? 0 : $urandom_range(0, 9);
         end
         if (hold_off) begin
            rsp_ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_ready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: checks words taken and feeds accepted bytes to the prediction.
   always @(posedge clock) begin
      req_fire = !reset && req_valid && req_ready;
      rsp_fire = !reset && rsp_valid && rsp_ready;
      if (rsp_fire) begin
         if (expected_words.size() == 0) begin
            $error("unexpected status word: index %0d value %0h",
                   rsp_word_index, rsp_word_value);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_word_index !== want.index) begin
               $error("word_index: expected %0d, got %0d", want.index, rsp_word_index);
               error_count++;
            end
            if (rsp_word_value !== want.value) begin
               $error("word_value: expected %0h, got %0h", want.value, rsp_word_value);
               error_count++;
            end
            if (rsp_separators_ok !== want.seps_ok) begin
               $error("separators_ok: expected %0b, got %0b",
                      want.seps_ok, rsp_separators_ok);
               error_count++;
            end
            if (rsp_last !== want.is_last) begin
               $error("last: expected %0b, got %0b", want.is_last, rsp_last);
               error_count++;
            end
         end
      end
      if (req_fire)
         deframe_byte(req_rx_byte);
   end

   // Once the first packet's words are due, the receiver stops for a long
   // stretch while the sender keeps offering bytes.
   initial begin
      while (words_predicted < WORDS)
         @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      // Loose bytes before any sync are ignored.
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      // Zero length: the byte after it is ignored.
      queue_sync();
      pending_bytes.push_back(8'd0);
      pending_bytes.push_back(8'h5A);
      // A short packet completes silently; the byte after it is ignored.
      queue_sync();
      pending_bytes.push_back(8'd2);
      pending_bytes.push_back(8'd1);
      pending_bytes.push_back(8'd2);
      pending_bytes.push_back(8'd9);
      // A sync whose first byte falls on the length position, then a sync
      // inside a payload, then the longest length.
      queue_sync();
      queue_sync();
      pending_bytes.push_back(8'd4);
      pending_bytes.push_back(8'h77);
      queue_sync();
      pending_bytes.push_back(8'd255);

      // A clean full packet, a short one, then a full packet with a spoilt
      // separator, and loose bytes behind it so that intake stalls again.
      queue_status_packet(1'b1, FULL_LENGTH);
      queue_other_packet();
      queue_status_packet(1'b0, FULL_LENGTH);
      queue_noise();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() > 0 || req_valid)
         @(posedge clock);
      while (expected_words.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (error_count == 0)
         $display("status_packet_deframer verification clean");
      else
         $display("status_packet_deframer verification failed");
      $finish;
   end

   initial begin
      #1000000;
      $display("status_packet_deframer verification failed");
      $finish;
   end

endmodule
